// File: src/rpn_pkg.sv
package rpn_pkg;

  localparam int unsigned DEF_STACK_DEPTH = 16;
  localparam int unsigned DEF_VALUE_BITS  = 32;
  localparam int unsigned OUT_BITS        = 32;
  // widest multiply done without the split multiplier
  localparam int unsigned MUL_MAX_BITS    = 32;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;

  localparam logic [1:0] FLAG_UNDER = 2'b01;
  localparam logic [1:0] FLAG_OVER  = 2'b10;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  typedef struct packed {
    logic [OUT_BITS-1:0] value;
    status_e             status;
  } result_t;

  function automatic status_e status_of(input logic [1:0] flags);
    status_e st;
    if ((flags & FLAG_UNDER) != 2'b00) begin
      st = ST_UNDER;
    end else if ((flags & FLAG_OVER) != 2'b00) begin
      st = ST_OVER;
    end else begin
      st = ST_OK;
    end
    return st;
  endfunction

endpackage

// File: src/postfix_expression_evaluator.sv
// Takes one character per cycle while in_stall_o is low; a final character's result
// beat is registered in the output queue. With VALUE_BITS above 32, '*' uses a split
// multiplier and holds the input until the product is ready. The stack sits in a 1W2R
// memory with the top mirrored in a register; a two-beat output queue raises in_stall_o
// when both beats wait. rst_ni clears depth, number, flags and the output queue at once;
// the stack memory needs no clearing pass since only entries below the depth are read.
module postfix_expression_evaluator
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int unsigned VALUE_BITS  = DEF_VALUE_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 char_code_i,
  input  logic                       is_final_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [OUT_BITS-1:0] value_o,
  output logic [1:0]                 status_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned W  = VALUE_BITS;
  localparam bit          MUL_SPLIT = (VALUE_BITS > MUL_MAX_BITS);

  localparam logic [DW-1:0] D_FULL  = DW'(STACK_DEPTH);
  localparam logic [DW-1:0] D_ONE   = DW'(1);
  localparam logic [DW-1:0] D_TWO   = DW'(2);
  localparam logic [DW-1:0] D_THREE = DW'(3);

  logic [DW-1:0] depth_q, depth_d;
  logic [W-1:0]  top_q, top_d;
  logic [W-1:0]  acc_q, acc_d;
  logic          nip_q, nip_d;
  logic [1:0]    flags_q, flags_d;
  logic          pend_q, pend_d;
  logic          pend_fin_q, pend_fin_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;
  status_e       pend_status_q, pend_status_d;

  logic          in_fire;
  logic          is_digit, is_plus, is_minus, is_star, is_arith, split_mul;
  logic          push_a, pop_b;
  logic [7:0]    dig8;
  logic [W-1:0]  acc_next, acc_push;
  logic [W-1:0]  sec_w, thr_w;
  logic [DW-1:0] d1, d2, d3, d3m1;
  logic [W-1:0]  v1, v2, v3;
  logic          ovf, und;
  logic [W-1:0]  opa, opb, res, mul_p;
  logic [W-1:0]  top_n, new_val, fin_val, res_val;
  logic          wr_c;
  logic [1:0]    flags_n;
  status_e       fin_status;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, wr_addr;
  logic [W-1:0]  mem_wdata;
  logic [DW-1:0] rd0_full, rd1_full;
  logic [AW-1:0] rd_addr0, rd_addr1;

  logic          res_push;
  result_t       res_data, q_data;
  logic          q_full;
  logic [OUT_BITS-1:0] res_ext;

  assign in_fire   = in_valid_i && !in_stall_o;
  assign in_stall_o = pend_q || q_full;

  assign is_digit  = (char_code_i >= CHAR_ZERO) && (char_code_i <= CHAR_NINE);
  assign is_plus   = (char_code_i == CHAR_PLUS);
  assign is_minus  = (char_code_i == CHAR_MINUS);
  assign is_star   = (char_code_i == CHAR_STAR);
  assign is_arith  = is_plus || is_minus || is_star;
  assign split_mul = MUL_SPLIT && is_star;

  assign dig8     = char_code_i - CHAR_ZERO;
  assign acc_next = (acc_q << 3) + (acc_q << 1) + {{(W-4){1'b0}}, dig8[3:0]};
  assign acc_push = is_digit ? acc_next : acc_q;
  // a number ends on any non-digit, or on the last character
  assign push_a   = is_digit ? is_final_i : nip_q;
  assign pop_b    = !is_digit && (char_code_i != CHAR_SPACE);

  // push the pending number
  always_comb begin
    d1   = depth_q;
    v1   = top_q;
    v2   = sec_w;
    v3   = thr_w;
    ovf  = 1'b0;
    if (push_a) begin
      if (depth_q == D_FULL) begin
        ovf = 1'b1;
      end else begin
        d1 = depth_q + D_ONE;
        v1 = acc_push;
        v2 = top_q;
        v3 = sec_w;
      end
    end
  end

  // missing operands read as zero
  assign opa = (d1 >= D_ONE) ? v1 : '0;
  assign opb = (d1 >= D_TWO) ? v2 : '0;

  always_comb begin
    case (char_code_i)
      CHAR_PLUS:  res = opb + opa;
      CHAR_MINUS: res = opb - opa;
      default:    res = mul_p;
    endcase
  end

  // pop two on any non-digit, non-space character; push the result only for an operator
  always_comb begin
    d2      = '0;
    d3      = d1;
    top_n   = v1;
    und     = 1'b0;
    wr_c    = push_a && !ovf;
    new_val = acc_push;
    if (pop_b) begin
      und = (d1 < D_TWO);
      d2  = (d1 >= D_TWO) ? d1 - D_TWO : '0;
      if (is_arith) begin
        d3      = d2 + D_ONE;
        top_n   = res;
        wr_c    = 1'b1;
        new_val = res;
      end else begin
        d3    = d2;
        top_n = v3;
        wr_c  = 1'b0;
      end
    end
  end

  assign d3m1       = d3 - D_ONE;
  assign wr_addr    = d3m1[AW-1:0];
  assign flags_n    = flags_q | (ovf ? FLAG_OVER : 2'b00) | (und ? FLAG_UNDER : 2'b00);
  assign fin_val    = (d3 >= D_ONE) ? top_n : '0;
  assign fin_status = status_of(flags_n | ((d3 == '0) ? FLAG_UNDER : 2'b00));

  always_comb begin
    depth_d       = depth_q;
    top_d         = top_q;
    acc_d         = acc_q;
    nip_d         = nip_q;
    flags_d       = flags_q;
    pend_d        = 1'b0;
    pend_fin_d    = pend_fin_q;
    pend_addr_d   = pend_addr_q;
    pend_status_d = pend_status_q;
    if (pend_q && !pend_fin_q) begin
      top_d = mul_p;
    end
    if (in_fire) begin
      if (is_final_i) begin
        depth_d = '0;
        acc_d   = '0;
        nip_d   = 1'b0;
        flags_d = '0;
      end else begin
        depth_d = d3;
        top_d   = top_n;
        acc_d   = is_digit ? acc_next : '0;
        nip_d   = is_digit;
        flags_d = flags_n;
      end
      if (split_mul) begin
        pend_d        = 1'b1;
        pend_fin_d    = is_final_i;
        pend_addr_d   = wr_addr;
        pend_status_d = fin_status;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      acc_q   <= '0;
      nip_q   <= 1'b0;
      flags_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      depth_q <= depth_d;
      acc_q   <= acc_d;
      nip_q   <= nip_d;
      flags_q <= flags_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q         <= top_d;
    pend_fin_q    <= pend_fin_d;
    pend_addr_q   <= pend_addr_d;
    pend_status_q <= pend_status_d;
  end

  // write lands at the new top; reads fetch the two entries beneath it,
  // so a write and a read never hit the same entry in one cycle
  assign mem_we    = (in_fire && wr_c && !is_final_i && !split_mul) ||
                     (pend_q && !pend_fin_q);
  assign mem_waddr = pend_q ? pend_addr_q : wr_addr;
  assign mem_wdata = pend_q ? mul_p : new_val;
  assign rd0_full  = depth_d - D_TWO;
  assign rd1_full  = depth_d - D_THREE;
  assign rd_addr0  = rd0_full[AW-1:0];
  assign rd_addr1  = rd1_full[AW-1:0];

  rpn_stack_mem #(
    .DEPTH(STACK_DEPTH),
    .W    (W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr0_i(rd_addr0),
    .raddr1_i(rd_addr1),
    .rdata0_o(sec_w),
    .rdata1_o(thr_w)
  );

  rpn_mul #(
    .W(W)
  ) u_mul (
    .clk_i(clk_i),
    .a_i  (opb),
    .b_i  (opa),
    .p_o  (mul_p)
  );

  assign res_val = pend_q ? mul_p : fin_val;

  if (W >= OUT_BITS) begin : g_trunc
    assign res_ext = res_val[OUT_BITS-1:0];
  end else begin : g_sext
    assign res_ext = {{(OUT_BITS-W){res_val[W-1]}}, res_val};
  end

  assign res_push        = (in_fire && is_final_i && !split_mul) || (pend_q && pend_fin_q);
  assign res_data.value  = res_ext;
  assign res_data.status = pend_q ? pend_status_q : fin_status;

  rpn_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_push),
    .push_data_i(res_data),
    .valid_o    (out_valid_o),
    .stall_i    (out_stall_i),
    .data_o     (q_data),
    .full_o     (q_full)
  );

  assign value_o  = $signed(q_data.value);
  assign status_o = q_data.status;

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= D_FULL)
    else $error("stack depth beyond capacity");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (mem_waddr != rd_addr0))
    else $error("stack write hits the entry being read");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_final_i) |=> (depth_q == '0 && !nip_q && flags_q == '0))
    else $error("state not cleared after last character");

  a_mul_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |=> !pend_q)
    else $error("split multiply took more than one extra cycle");

  a_result_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_final_i && !split_mul) |=> out_valid_o)
    else $error("no result beat after last character");
`endif

endmodule

// File: src/rpn_stack_mem.sv
module rpn_stack_mem
  import rpn_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_STACK_DEPTH,
  parameter int unsigned W     = DEF_VALUE_BITS,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr0_i,
  input  logic [AW-1:0] raddr1_i,
  output logic [W-1:0]  rdata0_o,
  output logic [W-1:0]  rdata1_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata0_q;
  logic [W-1:0] rdata1_q;

  // one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// File: src/rpn_mul.sv
module rpn_mul
  import rpn_pkg::*;
#(
  parameter int unsigned W = DEF_VALUE_BITS
) (
  input  logic         clk_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] p_o
);

  if (W > MUL_MAX_BITS) begin : g_split
    localparam int unsigned HB = W - MUL_MAX_BITS;

    logic [2*MUL_MAX_BITS-1:0] pp_ll_q;
    logic [HB-1:0]             pp_lh_q;
    logic [HB-1:0]             pp_hl_q;

    // partial products registered; the sum of the registered terms follows in the next cycle
    always_ff @(posedge clk_i) begin
      pp_ll_q <= (2*MUL_MAX_BITS)'(a_i[MUL_MAX_BITS-1:0]) *
                 (2*MUL_MAX_BITS)'(b_i[MUL_MAX_BITS-1:0]);
      pp_lh_q <= HB'(a_i[MUL_MAX_BITS-1:0] * b_i[W-1:MUL_MAX_BITS]);
      pp_hl_q <= HB'(a_i[W-1:MUL_MAX_BITS] * b_i[MUL_MAX_BITS-1:0]);
    end

    assign p_o = pp_ll_q[W-1:0] +
                 {HB'(pp_lh_q + pp_hl_q), {MUL_MAX_BITS{1'b0}}};
  end else begin : g_single
    assign p_o = W'(a_i * b_i);
  end

endmodule

// File: src/rpn_outq.sv
module rpn_outq
  import rpn_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    valid_o,
  input  logic    stall_i,
  output result_t data_o,
  output logic    full_o
);

  logic [1:0] count_q;
  logic [1:0] count_d;
  result_t    slot0_q;
  result_t    slot1_q;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = slot0_q;
  assign pop     = valid_o && !stall_i;
  assign count_d = count_q + {1'b0, push_i} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // slot0 is the head beat
  always_ff @(posedge clk_i) begin
    if (pop) begin
      slot0_q <= (count_q == 2'd2) ? slot1_q : push_data_i;
      if (push_i && count_q == 2'd2) begin
        slot1_q <= push_data_i;
      end
    end else if (push_i) begin
      if (count_q == 2'd0) begin
        slot0_q <= push_data_i;
      end else begin
        slot1_q <= push_data_i;
      end
    end
  end

endmodule
